@@ design/pdse_pkg.sv @@
// shared constants, codes and types of the postfix digit stack evaluator
`default_nettype none

package pdse_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned DATA_W          = 32;

  // character codes
  localparam logic [7:0] CH_TERM  = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_DIVZERO   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DIV,
    S_WRITE,
    S_EMIT
  } state_t;

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    is_oper = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

endpackage

`default_nettype wire

@@ design/postfix_digit_stack_evaluator_unit.sv @@
// top level of the postfix digit stack evaluator
// steps: digit, letter or ignored character done on acceptance; + - * fetch,
//   write back; / fetch, 32-step divider plus handoff, write back; ':' fetch
//   unless the stack is empty or an error is held, then the output register,
//   then one beat out when the consumer is ready; one character in work at a time
// reset: stack count, sticky error, state machine and output valid are cleared;
//   stack memory contents are left as they are
`default_nettype none

module postfix_digit_stack_evaluator_unit
  import pdse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          char_code,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [DATA_W-1:0] result_value,
  output logic [1:0]               status
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = $clog2(STACK_DEPTH);

  state_t state, state_next;

  // control state
  logic [CNT_W-1:0]  stk_count;
  logic [1:0]        err;

  // payload registers
  logic [7:0]        op;
  logic [DATA_W-1:0] rd_top;     // entry at count-1, right operand
  logic [DATA_W-1:0] rd_next;    // entry at count-2, left operand
  logic [DATA_W-1:0] wb;         // value written back by an operator
  logic              neg;        // quotient sign
  logic [DATA_W-1:0] res_value;
  logic [1:0]        res_status;

  // stack memory, two registered read ports and one write port
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     next_addr;

  // divider hookup
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;
  logic [DATA_W-1:0] abs_lhs;
  logic [DATA_W-1:0] abs_rhs;

  logic              in_fire;
  logic              stk_full;
  logic              stk_empty;
  logic              out_free;

  assign in_fire   = in_valid && in_ready;
  assign stk_full  = stk_count >= CNT_W'(STACK_DEPTH);
  assign stk_empty = stk_count == '0;
  assign out_free  = !out_valid || out_ready;
  assign top_addr  = AW'(stk_count - 1'b1);
  assign next_addr = AW'(stk_count - CNT_W'(2));
  assign abs_lhs   = rd_next[DATA_W-1] ? (~rd_next + 1'b1) : rd_next;
  assign abs_rhs   = rd_top[DATA_W-1]  ? (~rd_top + 1'b1)  : rd_top;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (char_code == CH_TERM) begin
            // error or empty stack needs no read
            state_next = (err != ST_OK || stk_empty) ? S_EMIT : S_FETCH;
          end else if (err == ST_OK && is_oper(char_code) &&
                       stk_count >= CNT_W'(2)) begin
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (op == CH_TERM) begin
          state_next = S_EMIT;
        end else if (op == CH_SLASH) begin
          state_next = (rd_top == '0) ? S_IDLE : S_DIV;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_DIV: begin
        if (div_done) state_next = S_WRITE;
      end
      S_WRITE: state_next = S_IDLE;
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = top_addr;
    mem_wd    = wb;
    div_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        // push goes straight into the memory on the accepting edge
        mem_wa   = AW'(stk_count);
        mem_wd   = DATA_W'(char_code - CH_ZERO);
        mem_we   = in_fire && err == ST_OK && is_alnum(char_code) && !stk_full;
      end
      S_FETCH: begin
        div_start = (op == CH_SLASH) && (rd_top != '0);
      end
      S_WRITE: begin
        mem_we = 1'b1;
        mem_wa = next_addr;
        mem_wd = wb;
      end
      S_DIV, S_EMIT: ;
      default: ;
    endcase
  end

  // reads are issued on the accepting edge; every write lands on an earlier edge
  // than the next accept, so reads never meet a write in flight
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (in_fire) begin
      rd_top  <= mem[top_addr];
      rd_next <= mem[next_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stk_count <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (char_code == CH_TERM) begin
              stk_count <= '0;
              err       <= ST_OK;
            end else if (err == ST_OK) begin
              if (is_alnum(char_code)) begin
                if (stk_full) err <= ST_OVERFLOW;
                else stk_count <= stk_count + 1'b1;
              end else if (is_oper(char_code) && stk_count < CNT_W'(2)) begin
                err <= ST_UNDERFLOW;
              end
            end
          end
        end
        S_FETCH: begin
          if (op == CH_SLASH && rd_top == '0) err <= ST_DIVZERO;
        end
        S_WRITE: stk_count <= stk_count - 1'b1;
        default: ;
      endcase
      // output register: load wins over drain
      if (state == S_EMIT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op <= char_code;
      if (char_code == CH_TERM) begin
        res_value <= '0;
        if (err != ST_OK) res_status <= err;
        else if (stk_empty) res_status <= ST_UNDERFLOW;
        else res_status <= ST_OK;
      end
    end
    if (state == S_FETCH) begin
      unique case (op)
        CH_TERM:  res_value <= rd_top;
        CH_PLUS:  wb <= rd_next + rd_top;
        CH_MINUS: wb <= rd_next - rd_top;
        CH_STAR:  wb <= rd_next * rd_top;
        CH_SLASH: neg <= rd_next[DATA_W-1] ^ rd_top[DATA_W-1];
        default: ;
      endcase
    end
    if (state == S_DIV && div_done) begin
      wb <= neg ? (~div_quot + 1'b1) : div_quot;
    end
    if (state == S_EMIT && out_free) begin
      result_value <= $signed(res_value);
      status       <= res_status;
    end
  end

  pdse_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (abs_lhs),
    .divisor  (abs_rhs),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

`default_nettype wire

@@ design/pdse_divider.sv @@
// iterative unsigned restoring divider, one quotient bit per cycle
`default_nettype none

module pdse_divider
  import pdse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic [DATA_W-1:0]      quotient
);

  localparam int unsigned STEP_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] dvsr;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted  = {rem, quot[DATA_W-1]};
  assign diff     = shifted - {1'b0, dvsr};
  assign quotient = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DATA_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem  <= diff[DATA_W-1:0];
        quot <= {quot[DATA_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[DATA_W-1:0];
        quot <= {quot[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ design/pdse_checker.sv @@
// port-level checker for the postfix digit stack evaluator and its bind
`default_nettype none

module pdse_checker
  import pdse_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic [7:0]          char_code,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic signed [DATA_W-1:0] result_value,
  input wire logic [1:0]          status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
    else $error("result beat changed while stalled");

  // any error status carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_value == '0)
    else $error("nonzero value with error status");

  // reset leaves the output empty and the input open
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // pushes and ignored characters leave the input ready again in the cycle after
  a_short: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && char_code != CH_TERM && !is_oper(char_code) |=> in_ready)
    else $error("single-cycle character did not release input");

endmodule

bind postfix_digit_stack_evaluator_unit pdse_checker u_pdse_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench of the postfix digit stack evaluator: directed and random character streams
`default_nettype none

module tb_top;
  import pdse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_SLOTS  = STACK_DEPTH_DEF;
  localparam int          RANDOM_BEATS = 2000;
  localparam int          CYCLE_LIMIT  = 1000000;
  // margin that covers any work still in flight, such as a divide
  localparam int          DRAIN_CYCLES = 100;
  localparam int          IDLE_PCT     = 30;

  // one emitted expression value with its status
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               st;
  } eval_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               char_code = 8'h00;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic [1:0]               status;

  // predictor state: its own copy of the operand stack and the sticky error
  logic [DATA_W-1:0] pred_stack [STACK_SLOTS];
  int unsigned       pred_count = 0;
  logic [1:0]        pred_error = ST_OK;

  eval_result_t expected_results [$];
  int           err_count       = 0;
  int           evaluated_chars = 0;
  int           cycle_count     = 0;
  // when set, neither side idles
  bit           calm_stretch    = 1'b0;

  postfix_digit_stack_evaluator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL postfix_digit_stack_evaluator_unit");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // digits and letters are operands
  function automatic bit is_operand_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // signed divide truncating toward zero, done on magnitudes so that the
  // most negative value over -1 wraps instead of trapping
  function automatic logic [DATA_W-1:0] div_toward_zero(input logic [DATA_W-1:0] a,
                                                        input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] mag_a, mag_b, quo;
    mag_a = a[DATA_W-1] ? (~a + 1'b1) : a;
    mag_b = b[DATA_W-1] ? (~b + 1'b1) : b;
    quo   = mag_a / mag_b;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? (~quo + 1'b1) : quo;
  endfunction

  // advance the predicted stack by one character; returns 1 when the
  // character has any effect (ignored characters return 0)
  function automatic bit eval_char(input logic [7:0] c);
    eval_result_t      res;
    logic [DATA_W-1:0] lhs, rhs, r;
    if (c == CH_TERM) begin
      res.value = '0;
      res.st    = pred_error;
      if (pred_error == ST_OK) begin
        // terminator on an empty stack counts as underflow
        if (pred_count == 0) res.st = ST_UNDERFLOW;
        else res.value = pred_stack[pred_count-1];
      end
      expected_results.push_back(res);
      pred_count = 0;
      pred_error = ST_OK;
      return 1'b1;
    end
    // after the first error everything up to the terminator is dropped
    if (pred_error != ST_OK) return 1'b0;
    if (is_operand_char(c)) begin
      if (pred_count >= STACK_SLOTS) begin
        pred_error = ST_OVERFLOW;
      end else begin
        pred_stack[pred_count] = DATA_W'(c) - DATA_W'(CH_ZERO);
        pred_count++;
      end
      return 1'b1;
    end
    if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      if (pred_count < 2) begin
        pred_error = ST_UNDERFLOW;
        return 1'b1;
      end
      rhs = pred_stack[pred_count-1];
      lhs = pred_stack[pred_count-2];
      case (c)
        CH_PLUS:  r = lhs + rhs;
        CH_MINUS: r = lhs - rhs;
        CH_STAR:  r = lhs * rhs;
        default: begin
          if (rhs == '0) begin
            pred_error = ST_DIVZERO;
            return 1'b1;
          end
          r = div_toward_zero(lhs, rhs);
        end
      endcase
      pred_stack[pred_count-2] = r;
      pred_count--;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // send one character beat; called at a rising edge, returns at the edge
  // where the beat was taken, leaving valid high for a back-to-back beat
  task automatic send_char(input logic [7:0] c);
    while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (eval_char(c)) evaluated_chars++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] random_operand_char();
    case ($urandom_range(2))
      0:       return 8'h30 + 8'($urandom_range(9));
      1:       return 8'h41 + 8'($urandom_range(25));
      default: return 8'h61 + 8'($urandom_range(25));
    endcase
  endfunction

  function automatic logic [7:0] random_operator_char();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // receiver side: ready idles at random except in the calm stretch
  always @(posedge clk) begin
    out_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
  end

  // result checker: each taken beat against the oldest expectation
  always @(posedge clk) begin
    eval_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                  result_value, status));
      end else begin
        exp_res = expected_results.pop_front();
        if (result_value !== exp_res.value)
          report_mismatch($sformatf("result_value got %0d expected %0d",
                                    result_value, exp_res.value));
        if (status !== exp_res.st)
          report_mismatch($sformatf("status got %0d expected %0d", status, exp_res.st));
      end
    end
  end

  // terminator alone, operator on too few entries, characters after an error
  task automatic test_underflow();
    send_string(":");
    send_string("+:");
    send_string("5-3:");
  endtask

  // all four operators, including a negative quotient that truncates toward zero
  task automatic test_operators();
    send_string("93-4*2/7+:");
    send_string("07-2/:");
  endtask

  // divide by zero, and the most negative value over -1 (32^6 * 2 = 2^31)
  task automatic test_divide_cases();
    send_string("90/:");
    send_string("PP*P*P*P*P*2*01-/:");
  endtask

  // field extremes and ignored codes while filling the stack past full
  task automatic test_overflow_and_extremes();
    send_string("09AZaz");
    send_char(8'h00);
    send_char(8'hFF);
    send_string("0123456789z:");
  endtask

  // mostly well-formed expressions with random content, then overflow runs,
  // raw noise and broken sequences
  task automatic test_random_streams();
    int start_count, kind, n, pushes, depth;
    start_count = evaluated_chars;
    while (evaluated_chars < start_count + RANDOM_BEATS) begin
      calm_stretch = (evaluated_chars >= start_count + 800) &&
                     (evaluated_chars <  start_count + 1100);
      kind = $urandom_range(99);
      if (kind < 70) begin
        n      = $urandom_range(1, 10);
        pushes = 0;
        depth  = 0;
        while (!(pushes == n && depth == 1)) begin
          if ($urandom_range(99) < 5) send_char(8'h20);
          if (pushes < n && (depth < 2 || $urandom_range(1) == 0)) begin
            send_char(random_operand_char());
            pushes++;
            depth++;
          end else begin
            send_char(random_operator_char());
            depth--;
          end
        end
        send_char(CH_TERM);
      end else if (kind < 80) begin
        // fill up to and beyond the stack depth
        n = $urandom_range(STACK_SLOTS - 2, STACK_SLOTS + 2);
        for (int i = 0; i < n; i++) send_char(random_operand_char());
        if ($urandom_range(1) == 0) send_char(random_operator_char());
        send_char(CH_TERM);
      end else if (kind < 95) begin
        // any byte at all
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) send_char(8'($urandom_range(255)));
        send_char(CH_TERM);
      end else begin
        // operands and operators in random order, sometimes not terminated
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(1) == 0) send_char(random_operand_char());
          else send_char(random_operator_char());
        end
        if ($urandom_range(1) == 0) send_char(CH_TERM);
      end
    end
    calm_stretch = 1'b0;
    // close any open expression so its result is checked too
    send_char(CH_TERM);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_underflow();
    test_operators();
    test_divide_cases();
    test_overflow_and_extremes();
    test_random_streams();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (err_count == 0) begin
      $display("PASS postfix_digit_stack_evaluator_unit");
    end else begin
      $display("FAIL postfix_digit_stack_evaluator_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ postfix_digit_stack_evaluator_unit.f @@
design/pdse_pkg.sv
design/pdse_divider.sv
design/postfix_digit_stack_evaluator_unit.sv
design/pdse_checker.sv
tb/tb_top.sv
